[src/card_id_access_table_defines.svh]
// ----------------------------------------------------------------------------
// Card ID access table assertion macros
// Concurrent assertion wrappers used by the top-level card table module.
// ----------------------------------------------------------------------------
`ifndef CARD_ID_ACCESS_TABLE_DEFINES_SVH
`define CARD_ID_ACCESS_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk and suspended during reset.
`define CIDA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("card table assertion failed");
// Next-cycle implication, sampled on i_clk and suspended during reset.
`define CIDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("card table assertion failed");
`else
`define CIDA_ASSERT_IMPL(label, ante, cons)
`define CIDA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[src/cida_pkg.sv]
// ----------------------------------------------------------------------------
// Card ID access table package
// Widths, codes, state type and controller/datapath command/status structs.
// ----------------------------------------------------------------------------
package cida_pkg;

    localparam int UID_W          = 40;
    localparam int OP_W           = 2;
    localparam int CODE_W         = 3;
    localparam int SLOT_W         = 5;
    localparam int SLOT_COUNT_DEF = 20;

    localparam logic [UID_W-1:0] ADMIN_RESET = 40'h13_5F54_2D35;
    localparam logic [UID_W-1:0] EMPTY_UID   = {UID_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_CHECK  = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    typedef enum logic [CODE_W-1:0] {
        RC_GRANTED   = 3'd0,
        RC_ADMIN     = 3'd1,
        RC_DENIED    = 3'd2,
        RC_ADDED     = 3'd3,
        RC_DUPLICATE = 3'd4,
        RC_FULL      = 3'd5,
        RC_DELETED   = 3'd6,
        RC_EMPTY     = 3'd7
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the incoming transaction and restart the scan
        logic rd_en;   // read the slot at the scan address and advance it
        logic commit;  // update the table and load the result register
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic addr_last;  // the scan address points at the final slot
    } t_ctl_sts;

endpackage

[src/cida_if.sv]
// ----------------------------------------------------------------------------
// Card ID access table channel interfaces
// Valid/ready channels for requests and for results.
// ----------------------------------------------------------------------------
interface cida_in_if import cida_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [UID_W-1:0]  card_uid;

    modport source (output valid, output opcode, output card_uid, input ready);
    modport sink   (input valid, input opcode, input card_uid, output ready);
endinterface

interface cida_out_if import cida_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] result_code;
    logic [SLOT_W-1:0] slot_number;

    modport source (output valid, output result_code, output slot_number, input ready);
    modport sink   (input valid, input result_code, input slot_number, output ready);
endinterface

[src/cida_ctrl.sv]
// ----------------------------------------------------------------------------
// Card ID access table controller
// Sequences capture, slot scan, pipeline drain and commit of one transaction.
// ----------------------------------------------------------------------------
module cida_ctrl import cida_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // The result register can take a new result when empty or being drained.
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.addr_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_COMMIT: begin
                o_cmd.commit = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[src/cida_datapath.sv]
// ----------------------------------------------------------------------------
// Card ID access table datapath
// Slot memory, scan pipeline, match flags, decision logic and result register.
// ----------------------------------------------------------------------------
module cida_datapath import cida_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [UID_W-1:0]  i_cfg_wr_data,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [UID_W-1:0]  i_card_uid,
    input  t_ctl_cmd          i_cmd,
    output t_ctl_sts          o_sts,
    output logic [CODE_W-1:0] o_result_code,
    output logic [SLOT_W-1:0] o_slot_number
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Slot storage; an entry without its valid bit reads as empty.
    logic [UID_W-1:0]      r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_valid;

    logic [UID_W-1:0]  r_admin;
    logic [OP_W-1:0]   r_op;
    logic [UID_W-1:0]  r_uid;

    logic [AW-1:0]     r_addr;
    logic              r_rd_pend;
    logic [AW-1:0]     r_rd_idx;
    logic [UID_W-1:0]  r_rd_data;
    logic              r_rd_vld;

    logic              r_hit_found;
    logic [AW-1:0]     r_hit_idx;
    logic              r_emp_found;
    logic [AW-1:0]     r_emp_idx;
    logic              r_any_used;

    logic [CODE_W-1:0] r_code;
    logic [SLOT_W-1:0] r_slot;

    logic [UID_W-1:0]  w_entry;
    logic              w_match;
    logic              w_empty;
    logic [AW:0]       w_hit_num;
    logic [AW:0]       w_emp_num;
    t_result           w_code;
    logic [SLOT_W-1:0] w_slot;
    logic              w_do_add;
    logic              w_do_del;

    assign o_sts.addr_last = (r_addr == AW'(SLOT_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_admin <= ADMIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_admin <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_uid <= i_card_uid;
        end
    end

    // Scan address and read-pending flag for the registered slot read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_addr <= '0;
            end else if (i_cmd.rd_en && !o_sts.addr_last) begin
                r_addr <= r_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_addr];
            r_rd_vld  <= r_valid[r_addr];
            r_rd_idx  <= r_addr;
        end
    end

    assign w_entry = r_rd_vld ? r_rd_data : EMPTY_UID;
    assign w_match = (w_entry == r_uid);
    assign w_empty = (w_entry == EMPTY_UID);

    // First-match, first-empty and occupancy flags gathered during the scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_hit_found <= 1'b0;
            r_hit_idx   <= '0;
            r_emp_found <= 1'b0;
            r_emp_idx   <= '0;
            r_any_used  <= 1'b0;
        end else if (r_rd_pend) begin
            if (w_match && !r_hit_found) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= r_rd_idx;
            end
            if (w_empty && !r_emp_found) begin
                r_emp_found <= 1'b1;
                r_emp_idx   <= r_rd_idx;
            end
            if (!w_empty) begin
                r_any_used <= 1'b1;
            end
        end
    end

    assign w_hit_num = {1'b0, r_hit_idx} + (AW+1)'(1);
    assign w_emp_num = {1'b0, r_emp_idx} + (AW+1)'(1);

    always_comb begin
        w_code   = RC_DENIED;
        w_slot   = '0;
        w_do_add = 1'b0;
        w_do_del = 1'b0;
        unique case (r_op)
            OP_CHECK: begin
                if (r_uid == r_admin) begin
                    w_code = RC_ADMIN;
                end else if (r_hit_found) begin
                    w_code = RC_GRANTED;
                    w_slot = SLOT_W'(w_hit_num);
                end
            end
            OP_ADD: begin
                if (r_hit_found) begin
                    w_code = RC_DUPLICATE;
                    w_slot = SLOT_W'(w_hit_num);
                end else if (r_emp_found) begin
                    w_code   = RC_ADDED;
                    w_slot   = SLOT_W'(w_emp_num);
                    w_do_add = 1'b1;
                end else begin
                    w_code = RC_FULL;
                end
            end
            OP_DELETE: begin
                if (!r_any_used) begin
                    w_code = RC_EMPTY;
                end else if (r_hit_found) begin
                    w_code   = RC_DELETED;
                    w_slot   = SLOT_W'(w_hit_num);
                    w_do_del = 1'b1;
                end
            end
            default: begin
                w_code = RC_DENIED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_do_add) begin
            r_mem[r_emp_idx] <= r_uid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit) begin
            if (w_do_add) begin
                r_valid[r_emp_idx] <= 1'b1;
            end
            if (w_do_del) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_code <= w_code;
            r_slot <= w_slot;
        end
    end

    assign o_result_code = r_code;
    assign o_slot_number = r_slot;

endmodule

[src/card_id_access_table.sv]
// ----------------------------------------------------------------------------
// Card ID access table
// Door controller table of card IDs with check, add and delete operations.
// ----------------------------------------------------------------------------
// Usage: each request transaction on i_in carries an opcode (check, add,
// delete) and a 40-bit card ID, and produces exactly one result transaction
// on o_out with a result code and a one-based slot number.
// The admin card ID is written through i_cfg_wr_en and i_cfg_wr_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce; it then takes effect on the next request. Each request
// is served by a scan that reads one slot per cycle from the slot memory:
// the request is captured, every slot is read, the registered read is
// drained, and the result is loaded into the output register. A new request
// can be taken from the cycle after the result is loaded onward.
// The result sits in an output register; a stalled receiver holds it there
// while the block still accepts and scans the next request, and only the
// commit of that next request waits for the register to drain.
// Reset empties every slot at once through per-slot valid bits, restores
// the default admin ID and drops any pending result.
// ----------------------------------------------------------------------------
`include "card_id_access_table_defines.svh"

module card_id_access_table import cida_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [UID_W-1:0] i_cfg_wr_data,
    cida_in_if.sink          i_in,
    cida_out_if.source       o_out
);

    // Command and status between the controller and the datapath.
    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    // The controller owns the handshakes and the phase of the transaction.
    cida_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the slots, the admin ID and the result register.
    cida_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_opcode      (i_in.opcode),
        .i_card_uid    (i_in.card_uid),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_result_code (o_out.result_code),
        .o_slot_number (o_out.slot_number)
    );

    // Once a request is taken, the block is busy scanning in the next cycle.
    `CIDA_ASSERT_NEXT(a_busy_after_accept, i_in.valid && i_in.ready, !i_in.ready)
    // A commit always leaves a result waiting on the output channel.
    `CIDA_ASSERT_NEXT(a_commit_gives_result, w_cmd.commit, o_out.valid)
    // Capture, scan read and commit never overlap.
    `CIDA_ASSERT_IMPL(a_cmd_exclusive, 1'b1, $onehot0({w_cmd.load, w_cmd.rd_en, w_cmd.commit}))
    // A commit never overwrites a result the receiver has not taken.
    `CIDA_ASSERT_IMPL(a_no_overwrite, w_cmd.commit, !o_out.valid || o_out.ready)

endmodule

[sim/card_table_checker.sv]
// ----------------------------------------------------------------------------
// Card ID access table checker
// Watches the request and result channels and the admin ID write port, keeps
// its own copy of the card table, predicts the answer to every accepted
// request and compares it field by field with the result that comes back.
// ----------------------------------------------------------------------------
module card_table_checker import cida_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [UID_W-1:0] i_cfg_wr_data,
    cida_in_if               i_req,
    cida_out_if              i_rsp,
    output int               o_pending,
    output int               o_fail_count
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        t_result           code;
        logic [SLOT_W-1:0] slot;
    } t_answer;

    logic [UID_W-1:0] slot_ids [SLOT_COUNT];
    logic [UID_W-1:0] admin_id;
    t_answer          awaited_answers [$];
    int               fail_total = 0;

    task automatic report_mismatch(input string what);
        if (fail_total < PRINT_LIMIT) begin
            $display("card table mismatch at %0t: %s", $realtime, what);
        end
        fail_total++;
    endtask

    // Index of the first slot that holds the ID, or SLOT_COUNT when none does.
    function automatic int first_slot_holding(input logic [UID_W-1:0] id);
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_ids[i] == id) return i;
        end
        return SLOT_COUNT;
    endfunction

    function automatic logic table_is_empty();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_ids[i] != EMPTY_UID) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Answers one request and applies its effect on the table.
    function automatic t_answer serve_request(input logic [OP_W-1:0] op,
                                              input logic [UID_W-1:0] id);
        t_answer ans;
        int      hit;
        ans.code = RC_DENIED;
        ans.slot = '0;
        case (op)
            OP_CHECK: begin
                if (id == admin_id) begin
                    ans.code = RC_ADMIN;
                end else begin
                    hit = first_slot_holding(id);
                    if (hit < SLOT_COUNT) begin
                        ans.code = RC_GRANTED;
                        ans.slot = SLOT_W'(hit + 1);
                    end
                end
            end
            OP_ADD: begin
                hit = first_slot_holding(id);
                if (hit < SLOT_COUNT) begin
                    ans.code = RC_DUPLICATE;
                    ans.slot = SLOT_W'(hit + 1);
                end else begin
                    hit = first_slot_holding(EMPTY_UID);
                    if (hit < SLOT_COUNT) begin
                        slot_ids[hit] = id;
                        ans.code      = RC_ADDED;
                        ans.slot      = SLOT_W'(hit + 1);
                    end else begin
                        ans.code = RC_FULL;
                    end
                end
            end
            OP_DELETE: begin
                if (table_is_empty()) begin
                    ans.code = RC_EMPTY;
                end else begin
                    hit = first_slot_holding(id);
                    if (hit < SLOT_COUNT) begin
                        slot_ids[hit] = EMPTY_UID;
                        ans.code      = RC_DELETED;
                        ans.slot      = SLOT_W'(hit + 1);
                    end
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch
        t_answer want;
        if (!i_rst_n) begin
            foreach (slot_ids[i]) slot_ids[i] = EMPTY_UID;
            admin_id = ADMIN_RESET;
            awaited_answers.delete();
        end else begin
            if (i_cfg_wr_en) begin
                admin_id = i_cfg_wr_data;
            end
            // Results leave before the request of the same edge can matter.
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_answers.size() == 0) begin
                    report_mismatch($sformatf("unexpected result code %0d slot %0d",
                                              i_rsp.result_code, i_rsp.slot_number));
                end else begin
                    want = awaited_answers.pop_front();
                    if (i_rsp.result_code !== want.code) begin
                        report_mismatch($sformatf("result_code %0d, expected %0d",
                                                  i_rsp.result_code, want.code));
                    end
                    if (i_rsp.slot_number !== want.slot) begin
                        report_mismatch($sformatf("slot_number %0d, expected %0d",
                                                  i_rsp.slot_number, want.slot));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                awaited_answers.push_back(serve_request(i_req.opcode, i_req.card_uid));
            end
        end
        o_pending    <= awaited_answers.size();
        o_fail_count <= fail_total;
    end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Card ID access table testbench
// Drives check, add and delete requests into the card table under random
// idling on both channels, rewrites the admin ID between phases, and leaves
// prediction and comparison to the checker that sits beside the block.
// ----------------------------------------------------------------------------
module testbench;
    import cida_pkg::*;

    // Overall time budget in time units; the slowest correct run needs a
    // small fraction of it.
    localparam int RUN_LIMIT    = 400000;
    localparam int RESET_CYCLES = 7;
    localparam int POOL_SIZE    = 28;
    localparam int PHASE_COUNT  = 5;
    localparam int PHASE_ITEMS  = 110;
    localparam int IDLE_PCT     = 13;
    localparam int UNUSED_PCT   = 3;
    localparam int HOLD_CYCLES  = 250;
    localparam int HOLD_COUNT   = 2;

    // The opcode value that the package leaves without a name.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [UID_W-1:0] cfg_wr_data;
    int               pending_count;
    int               fail_count;

    // High for the phase in which neither side idles at random.
    logic             quiet_phase;
    // Number of request transactions accepted so far.
    int               sent_count;
    // Admin ID currently written into the block, used to aim requests at it.
    logic [UID_W-1:0] admin_now;
    // A small set of card IDs reused over and over, so that adds fill the
    // table and checks and deletes actually find what was added.
    logic [UID_W-1:0] card_pool [POOL_SIZE];

    cida_in_if  req_ch ();
    cida_out_if rsp_ch ();

    card_id_access_table i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (req_ch),
        .o_out         (rsp_ch)
    );

    card_table_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_pending     (pending_count),
        .o_fail_count  (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses a transaction.
    initial begin
        #RUN_LIMIT;
        $display("testbench: errors");
        $finish;
    end

    // Result side. Ready idles at random except in the quiet phase. Twice in
    // the run it is held low for a long stretch while requests keep coming,
    // so that the output register stays full and the block has to stall its
    // request channel.
    initial begin : receiver
        int hold_left;
        int hold_idx;
        int hold_points [HOLD_COUNT];
        hold_left   = 0;
        hold_idx    = 0;
        hold_points = '{150, 400};
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_idx < HOLD_COUNT && sent_count >= hold_points[hold_idx]) begin
                rsp_ch.ready <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                hold_idx++;
            end else begin
                rsp_ch.ready <= quiet_phase || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Offers one request and returns at the edge where it is accepted. The
    // valid line is left high so that back-to-back requests need no gap.
    task automatic offer_request(input logic [OP_W-1:0] op, input logic [UID_W-1:0] uid);
        while (!quiet_phase && $urandom_range(0, 99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.opcode   <= op;
        req_ch.card_uid <= uid;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent_count <= sent_count + 1;
    endtask

    // Stops offering and waits until every accepted request has its result.
    // The first edge lets the checker count the last accepted transaction.
    task automatic drain_block();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    // Writes the admin ID; only called while the block is idle.
    task automatic write_admin(input logic [UID_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        admin_now = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // A small share of requests uses the unused opcode; the rest follow the
    // weights of the phase, with checks taking what is left.
    function automatic logic [OP_W-1:0] pick_op(input int add_pct, input int del_pct);
        int roll;
        if ($urandom_range(0, 99) < UNUSED_PCT) return OP_UNUSED;
        roll = $urandom_range(0, 99);
        if (roll < add_pct) return OP_ADD;
        if (roll < add_pct + del_pct) return OP_DELETE;
        return OP_CHECK;
    endfunction

    // Mostly IDs from the pool, then fully random IDs, the all-ones ID that
    // matches an empty slot, the current admin ID, zero and single-bit IDs.
    function automatic logic [UID_W-1:0] pick_uid();
        logic [63:0] raw;
        int          roll;
        raw  = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 68) return card_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (roll < 80) return raw[UID_W-1:0];
        if (roll < 87) return EMPTY_UID;
        if (roll < 94) return admin_now;
        if (roll < 97) return '0;
        return UID_W'(1) << $urandom_range(0, UID_W - 1);
    endfunction

    initial begin : stimulus
        int          add_weight [PHASE_COUNT];
        int          del_weight [PHASE_COUNT];
        logic [63:0] raw;

        // Phase mix: balanced, add-heavy to fill the table, delete-heavy to
        // empty it again, then balanced and add-heavy once more.
        add_weight = '{35, 55, 20, 35, 55};
        del_weight = '{25, 15, 55, 25, 15};

        req_ch.valid    = 1'b0;
        req_ch.opcode   = OP_CHECK;
        req_ch.card_uid = '0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        quiet_phase     = 1'b0;
        admin_now       = ADMIN_RESET;
        rst_n           = 1'b0;
        foreach (card_pool[i]) begin
            raw          = {$urandom, $urandom};
            card_pool[i] = raw[UID_W-1:0];
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the admin ID left at its reset value. Delete on
        // a fresh table reports the empty table; the admin ID is answered as
        // admin on check but handled as a plain card by add and delete.
        offer_request(OP_DELETE, 40'h12_3456_789A);
        offer_request(OP_CHECK,  ADMIN_RESET);
        offer_request(OP_CHECK,  40'h12_3456_789A);
        // The all-ones ID matches the first empty slot: add reports it as a
        // duplicate and check grants it.
        offer_request(OP_ADD,    EMPTY_UID);
        offer_request(OP_CHECK,  EMPTY_UID);
        offer_request(OP_DELETE, EMPTY_UID);
        offer_request(OP_ADD,    '0);
        offer_request(OP_ADD,    40'hFF_FFFF_FFFE);
        offer_request(OP_ADD,    40'h80_0000_0000);
        offer_request(OP_ADD,    '0);
        offer_request(OP_ADD,    ADMIN_RESET);
        offer_request(OP_CHECK,  ADMIN_RESET);
        offer_request(OP_CHECK,  40'hFF_FFFF_FFFE);
        offer_request(OP_DELETE, ADMIN_RESET);
        offer_request(OP_DELETE, 40'h00_0000_0001);
        // Deleting the all-ones ID on a table that is not empty clears the
        // first empty slot and reports it as deleted.
        offer_request(OP_DELETE, EMPTY_UID);
        offer_request(OP_CHECK,  EMPTY_UID);
        offer_request(OP_ADD,    EMPTY_UID);
        // The unused opcode leaves the table alone and answers denied.
        offer_request(OP_UNUSED, EMPTY_UID);
        offer_request(OP_UNUSED, '0);
        offer_request(OP_DELETE, '0);
        offer_request(OP_DELETE, 40'hFF_FFFF_FFFE);
        offer_request(OP_DELETE, 40'h80_0000_0000);
        offer_request(OP_DELETE, '0);

        // Random phases, each under its own admin ID: both extremes, one of
        // the pool IDs so that add and delete meet it, and random values.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_block();
            case (ph)
                0: write_admin('0);
                1: write_admin(EMPTY_UID);
                3: write_admin(card_pool[0]);
                default: begin
                    raw = {$urandom, $urandom};
                    write_admin(raw[UID_W-1:0]);
                end
            endcase
            quiet_phase <= (ph == 1);
            repeat (PHASE_ITEMS) begin
                offer_request(pick_op(add_weight[ph], del_weight[ph]), pick_uid());
            end
        end

        drain_block();
        // Give a stray extra result time to show up before the verdict.
        repeat (SLOT_COUNT_DEF + 8) @(posedge clk);
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

[card_id_access_table.f]
+incdir+src
src/cida_pkg.sv
src/cida_if.sv
src/cida_ctrl.sv
src/cida_datapath.sv
src/card_id_access_table.sv
sim/card_table_checker.sv
sim/testbench.sv
